[src/gr_cell_pkg.sv]
// ----------------------------------------------------------------------------
// gr_cell_pkg
// Shared types and constants for the Givens rotation internal cell: the word
// width, the request and response transaction types and the link to the
// shared multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gr_cell_pkg;

   // Word width of every data field (signed fixed point).
   localparam int unsigned DATA_WIDTH = 32;

   typedef logic [DATA_WIDTH-1:0] gr_word_type;

   typedef struct packed {
      logic                         req_type;
      logic signed [DATA_WIDTH-1:0] x_in;
      logic signed [DATA_WIDTH-1:0] y_in;
      logic signed [DATA_WIDTH-1:0] w_in;
   } gr_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] x_out;
      logic signed [DATA_WIDTH-1:0] y_out;
      logic signed [DATA_WIDTH-1:0] w_out;
   } gr_rsp_type;

   // Operation codes of the shared arithmetic unit.
   typedef enum logic {
      OP_MUL,
      OP_DIV
   } gr_op_type;

   typedef struct packed {
      logic        start;
      gr_op_type   op;
      gr_word_type a;
      gr_word_type b;
   } gr_unit_req_type;

   typedef struct packed {
      logic        done;
      gr_word_type result;
   } gr_unit_rsp_type;

endpackage

`default_nettype wire

[src/gr_cell_arith.sv]
// ----------------------------------------------------------------------------
// gr_cell_arith
// Shared fixed point multiply/divide unit: radix-2 shift-add multiply and
// restoring divide on magnitudes, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module gr_cell_arith #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  wire                           clock,
   input  wire                           reset,
   input  gr_cell_pkg::gr_unit_req_type  unit_req,
   output gr_cell_pkg::gr_unit_rsp_type  unit_rsp
);
   import gr_cell_pkg::*;

   localparam int unsigned DW  = DATA_WIDTH;
   localparam int unsigned DVW = DW + FRAC_BITS;
   localparam int unsigned CW  = $clog2(DVW + 1);
   localparam int unsigned PW  = 2 * DW;
   localparam int unsigned PXW = (PW > FRAC_BITS) ? PW : FRAC_BITS + 1;
   localparam int unsigned MW  = PXW + 1;
   localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_DIV,
      U_RND,
      U_DONE
   } ustate_type;

   ustate_type      state_ff, state_in;
   gr_op_type       op_ff, op_in;
   logic            neg_ff, neg_in;
   logic [DW-1:0]   ma_ff, ma_in;
   logic [DW-1:0]   mb_ff, mb_in;
   logic [DW-1:0]   acc_hi_ff, acc_hi_in;
   logic [DW-1:0]   acc_lo_ff, acc_lo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DVW-1:0]  dvd_ff, dvd_in;
   logic [DW:0]     q_ff, q_in;
   logic            ovf_ff, ovf_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]   result_ff, result_in;

   logic [DW-1:0]   a_mag, b_mag;
   logic [DW:0]     mul_sum;
   logic [DW-1:0]   div_r2;
   logic            div_ge;
   logic            div_rb;
   logic [DW+1:0]   div_qs;
   logic [PXW-1:0]  prod_ext;
   logic [MW-1:0]   mul_mfull;
   logic [DW:0]     fin_mag;
   logic            fin_big;
   logic [DW-1:0]   fin_word;

   assign a_mag = unit_req.a[DW-1] ? (~unit_req.a + 1'b1) : unit_req.a;
   assign b_mag = unit_req.b[DW-1] ? (~unit_req.b + 1'b1) : unit_req.b;

   // One multiply step and one divide step.
   always_comb begin
      mul_sum = {1'b0, acc_hi_ff} + (acc_lo_ff[0] ? {1'b0, ma_ff} : {(DW+1){1'b0}});
      div_r2  = {rem_ff[DW-2:0], dvd_ff[DVW-1]};
      div_ge  = (div_r2 >= mb_ff);
   end

   // Rounding and saturation of the finished magnitude.
   always_comb begin
      div_rb    = ({rem_ff, 1'b0} >= {1'b0, mb_ff});
      div_qs    = {1'b0, q_ff} + (DW+2)'(div_rb);
      prod_ext  = PXW'({acc_hi_ff, acc_lo_ff});
      mul_mfull = MW'(prod_ext >> FRAC_BITS) + MW'(prod_ext[FRAC_BITS-1]);
      if (op_ff == OP_DIV) begin
         fin_mag = div_qs[DW:0];
         fin_big = ovf_ff | div_qs[DW+1];
      end else begin
         fin_mag = mul_mfull[DW:0];
         fin_big = |mul_mfull[MW-1:DW+1];
      end
      if (neg_ff) begin
         fin_word = (fin_big || (fin_mag > {1'b0, SMIN})) ? SMIN : (~fin_mag[DW-1:0] + 1'b1);
      end else begin
         fin_word = (fin_big || (fin_mag > {1'b0, SMAX})) ? SMAX : fin_mag[DW-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      acc_hi_in = acc_hi_ff;
      acc_lo_in = acc_lo_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (unit_req.start) begin
               op_in     = unit_req.op;
               neg_in    = unit_req.a[DW-1] ^ unit_req.b[DW-1];
               ma_in     = a_mag;
               mb_in     = b_mag;
               acc_hi_in = '0;
               acc_lo_in = b_mag;
               rem_in    = '0;
               dvd_in    = DVW'(a_mag) << FRAC_BITS;
               q_in      = '0;
               ovf_in    = 1'b0;
               cnt_in    = '0;
               if (unit_req.op == OP_DIV && unit_req.b == '0) begin
                  // divide by zero: saturate toward the dividend's sign, zero over zero gives zero
                  if (unit_req.a == '0) begin
                     result_in = '0;
                  end else begin
                     result_in = unit_req.a[DW-1] ? SMIN : SMAX;
                  end
                  state_in = U_DONE;
               end else begin
                  state_in = (unit_req.op == OP_DIV) ? U_DIV : U_MUL;
               end
            end
         end
         U_MUL: begin
            acc_hi_in = mul_sum[DW:1];
            acc_lo_in = {mul_sum[0], acc_lo_ff[DW-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = U_RND;
            end
         end
         U_DIV: begin
            rem_in = div_ge ? (div_r2 - mb_ff) : div_r2;
            q_in   = {q_ff[DW-1:0], div_ge};
            ovf_in = ovf_ff | q_ff[DW];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DVW - 1)) begin
               state_in = U_RND;
            end
         end
         U_RND: begin
            result_in = fin_word;
            state_in  = U_DONE;
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      acc_hi_ff <= acc_hi_in;
      acc_lo_ff <= acc_lo_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      q_ff      <= q_in;
      ovf_ff    <= ovf_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign unit_rsp.done   = (state_ff == U_DONE);
   assign unit_rsp.result = result_ff;

endmodule

`default_nettype wire

[src/givens_rotation_internal_cell_core.sv]
// ----------------------------------------------------------------------------
// givens_rotation_internal_cell_core
// Internal cell of a square-root-free Givens rotation systolic array, signed
// fixed point, built around one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// The cell takes one request transaction at a time and drops req_ready until
// the result is in the output register. Every multiply and divide runs on one
// shared radix-2 unit, one bit per cycle, at the default Q8.24; a divide by
// zero skips the iterations. Apply issues three multiplies. Generate with x
// zero issues two multiplies; generate with x nonzero issues three multiplies
// and two divides. The result waits in an output register, so a new request
// is taken while the previous response is still pending. Results round half
// away from zero and saturate; divide by zero saturates toward the dividend's
// sign.
// ----------------------------------------------------------------------------
`default_nettype none

module givens_rotation_internal_cell_core #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  gr_cell_pkg::gr_req_type req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output gr_cell_pkg::gr_rsp_type rsp_data
);
   import gr_cell_pkg::*;

   localparam int unsigned DW = DATA_WIDTH;
   localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
   // 1.0 in fixed point, saturated when the format has no room for it
   localparam logic [DW-1:0] ONE_VAL =
      (FRAC_BITS >= DW - 1) ? SMAX : (DW'(1) << FRAC_BITS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_OUT
   } state_type;

   // Which operation is in flight on the shared unit.
   typedef enum logic [2:0] {
      ST_MUL_WY,   // w*y (generate) or w*s (apply)
      ST_MUL_TY,   // (previous)*y, then x_out
      ST_DIV_C,    // c = y/x
      ST_MUL_WX,   // w*x
      ST_DIV_W,    // new weight = (w*x)/x_out
      ST_MUL_CX    // c*x, then y_out
   } step_type;

   state_type       state_ff, state_in;
   step_type        step_ff, step_in;
   logic            gen_ff, gen_in;
   logic [DW-1:0]   x_ff, x_in;
   logic [DW-1:0]   y_ff, y_in;
   logic [DW-1:0]   w_ff, w_in;
   logic [DW-1:0]   rot_c_ff, rot_c_in;
   logic [DW-1:0]   rot_s_ff, rot_s_in;
   logic            rot_z_ff, rot_z_in;
   logic [DW-1:0]   hw_ff, hw_in;
   logic [DW-1:0]   xo_ff, xo_in;
   logic [DW-1:0]   yo_ff, yo_in;
   logic            start_ff, start_in;
   gr_op_type       op_ff, op_in;
   logic [DW-1:0]   opa_ff, opa_in;
   logic [DW-1:0]   opb_ff, opb_in;
   gr_rsp_type      rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   gr_unit_req_type unit_req;
   gr_unit_rsp_type unit_rsp;

   function automatic logic [DW-1:0] sat_add(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW-1:0] s;
      s = a + b;
      if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1]) begin
         s = a[DW-1] ? SMIN : SMAX;
      end
      return s;
   endfunction

   function automatic logic [DW-1:0] sat_sub(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW-1:0] s;
      s = a - b;
      if (a[DW-1] != b[DW-1] && s[DW-1] != a[DW-1]) begin
         s = a[DW-1] ? SMIN : SMAX;
      end
      return s;
   endfunction

   gr_cell_arith #(
      .FRAC_BITS (FRAC_BITS)
   ) u_arith (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign unit_req.start = start_ff;
   assign unit_req.op    = op_ff;
   assign unit_req.a     = opa_ff;
   assign unit_req.b     = opb_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      gen_in       = gen_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      rot_c_in     = rot_c_ff;
      rot_s_in     = rot_s_ff;
      rot_z_in     = rot_z_ff;
      hw_in        = hw_ff;
      xo_in        = xo_ff;
      yo_in        = yo_ff;
      start_in     = 1'b0;
      op_in        = op_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      rsp_in       = rsp_ff;
      // drop the response once it is taken
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // latch the transaction and launch the first multiply
               gen_in   = req_data.req_type;
               x_in     = req_data.x_in;
               y_in     = req_data.y_in;
               w_in     = req_data.w_in;
               yo_in    = '0;
               start_in = 1'b1;
               op_in    = OP_MUL;
               opa_in   = req_data.w_in;
               opb_in   = req_data.req_type ? req_data.y_in : rot_s_ff;
               step_in  = ST_MUL_WY;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (unit_rsp.done) begin
               unique case (step_ff)
                  ST_MUL_WY: begin
                     start_in = 1'b1;
                     op_in    = OP_MUL;
                     opa_in   = unit_rsp.result;
                     opb_in   = y_ff;
                     step_in  = ST_MUL_TY;
                  end
                  ST_MUL_TY: begin
                     xo_in = sat_add((gen_ff || rot_z_ff) ? x_ff : '0, unit_rsp.result);
                     if (gen_ff) begin
                        if (x_ff == '0) begin
                           // zero x: identity-like rotation, unit weight
                           rot_c_in = ONE_VAL;
                           rot_z_in = 1'b0;
                           rot_s_in = (y_ff == '0) ? ONE_VAL : y_ff;
                           hw_in    = ONE_VAL;
                           state_in = S_OUT;
                        end else begin
                           start_in = 1'b1;
                           op_in    = OP_DIV;
                           opa_in   = y_ff;
                           opb_in   = x_ff;
                           step_in  = ST_DIV_C;
                        end
                     end else begin
                        start_in = 1'b1;
                        op_in    = OP_MUL;
                        opa_in   = rot_c_ff;
                        opb_in   = x_ff;
                        step_in  = ST_MUL_CX;
                     end
                  end
                  ST_DIV_C: begin
                     rot_c_in = unit_rsp.result;
                     rot_s_in = y_ff;
                     rot_z_in = 1'b1;
                     start_in = 1'b1;
                     op_in    = OP_MUL;
                     opa_in   = w_ff;
                     opb_in   = x_ff;
                     step_in  = ST_MUL_WX;
                  end
                  ST_MUL_WX: begin
                     start_in = 1'b1;
                     op_in    = OP_DIV;
                     opa_in   = unit_rsp.result;
                     opb_in   = xo_ff;
                     step_in  = ST_DIV_W;
                  end
                  ST_DIV_W: begin
                     hw_in    = unit_rsp.result;
                     state_in = S_OUT;
                  end
                  ST_MUL_CX: begin
                     yo_in    = sat_sub(rot_z_ff ? y_ff : '0, unit_rsp.result);
                     state_in = S_OUT;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.x_out = xo_ff;
               rsp_in.y_out = yo_ff;
               rsp_in.w_out = hw_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rot_c_ff     <= '0;
         rot_s_ff     <= '0;
         rot_z_ff     <= 1'b0;
         hw_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         rot_c_ff     <= rot_c_in;
         rot_s_ff     <= rot_s_in;
         rot_z_ff     <= rot_z_in;
         hw_ff        <= hw_in;
      end
      step_ff <= step_in;
      gen_ff  <= gen_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      w_ff    <= w_in;
      xo_ff   <= xo_in;
      yo_ff   <= yo_in;
      op_ff   <= op_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      rsp_ff  <= rsp_in;
   end

   // The shared unit only finishes an operation that the sequencer launched.
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == S_RUN))
      else $error("arith unit finished outside of a running transaction");

   // Every accepted transaction launches the shared unit on the next cycle.
   a_accept_launch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (start_ff && op_ff == OP_MUL && step_ff == ST_MUL_WY))
      else $error("accepted transaction did not launch its first multiply");

   // A finished result never overwrites a response that is still pending.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_ready) |=>
         (state_ff == S_OUT && $stable(rsp_ff)))
      else $error("pending response overwritten");

   // Launches happen only while the unit is free, i.e. in the running state.
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == S_RUN && !unit_rsp.done))
      else $error("arith unit launched while busy or idle");

endmodule

`default_nettype wire

[tb/givens_rotation_internal_cell_core_tb.sv]
// ----------------------------------------------------------------------------
// givens_rotation_internal_cell_core_tb
// Self-checking bench for the Givens rotation internal cell: directed cases for
// the zero-x path, saturation and divide by zero, then random requests, mostly
// rows of a generate then applies, checked against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
`default_nettype none

module givens_rotation_internal_cell_core_tb;

   import gr_cell_pkg::*;

   localparam int unsigned DW = DATA_WIDTH;
   localparam int unsigned FB = 24;

   // Request kinds carried in req_type.
   localparam logic REQ_GENERATE = 1'b1;
   localparam logic REQ_APPLY    = 1'b0;

   // Fixed-point landmarks.
   localparam gr_word_type Q_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam gr_word_type Q_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam gr_word_type Q_ONE = (FB >= DW - 1) ? Q_MAX : gr_word_type'(64'd1 << FB);
   localparam gr_word_type Q_ULP = gr_word_type'(1);

   localparam int RANDOM_ITEMS  = 1750;
   localparam int SETTLE_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gr_req_type  req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gr_rsp_type  rsp_data;

   // Rotation state as the cell should hold it.
   gr_word_type rot_cos;
   gr_word_type rot_sin;
   logic        rot_zflag;
   gr_word_type held_w;

   gr_rsp_type  cell_outputs_due[$];
   gr_rsp_type  oldest_due;
   int          mismatch_count = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   int          stall_pct = 0;
   int          cycle_count = 0;

   givens_rotation_internal_cell_core #(
      .FRAC_BITS(FB)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic: round half away from zero, saturate to DW bits
   // ---------------------------------------------------------------------

   function automatic gr_word_type q_mag(gr_word_type v);
      return v[DW-1] ? ~v + 1'b1 : v;
   endfunction

   // Sign plus wide magnitude down to a saturated word.
   function automatic gr_word_type q_pack(logic neg, logic [127:0] mag);
      if (neg) begin
         if (mag > 128'(Q_MIN)) return Q_MIN;
         return ~mag[DW-1:0] + 1'b1;
      end
      if (mag > 128'(Q_MAX)) return Q_MAX;
      return mag[DW-1:0];
   endfunction

   function automatic gr_word_type q_mul(gr_word_type a, gr_word_type b);
      logic [127:0] prod;
      prod = 128'(q_mag(a)) * 128'(q_mag(b));
      prod = (prod + (128'd1 << (FB - 1))) >> FB;
      return q_pack(a[DW-1] ^ b[DW-1], prod);
   endfunction

   function automatic gr_word_type q_div(gr_word_type a, gr_word_type b);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      logic [127:0] rem;
      if (b == '0) begin
         if (a == '0) return '0;
         return a[DW-1] ? Q_MIN : Q_MAX;
      end
      num = 128'(q_mag(a)) << FB;
      den = 128'(q_mag(b));
      quo = num / den;
      rem = num % den;
      // round the half and above away from zero
      if (rem >= den - rem) quo = quo + 1'b1;
      return q_pack(a[DW-1] ^ b[DW-1], quo);
   endfunction

   function automatic gr_word_type q_add(gr_word_type a, gr_word_type b);
      gr_word_type sum;
      sum = a + b;
      if (a[DW-1] == b[DW-1] && sum[DW-1] != a[DW-1]) return a[DW-1] ? Q_MIN : Q_MAX;
      return sum;
   endfunction

   function automatic gr_word_type q_sub(gr_word_type a, gr_word_type b);
      gr_word_type diff;
      diff = a - b;
      if (a[DW-1] != b[DW-1] && diff[DW-1] != a[DW-1]) return a[DW-1] ? Q_MIN : Q_MAX;
      return diff;
   endfunction

   // One cell step: work out the outputs and advance the rotation state.
   function automatic gr_rsp_type givens_step(gr_req_type t);
      gr_rsp_type  r;
      gr_word_type x;
      gr_word_type y;
      gr_word_type w;
      x = t.x_in;
      y = t.y_in;
      w = t.w_in;
      if (t.req_type == REQ_GENERATE) begin
         r.x_out = q_add(x, q_mul(q_mul(w, y), y));
         r.y_out = '0;
         if (x == '0) begin
            // zero x: identity-like rotation, s falls back to 1.0 when y is zero
            rot_cos   = Q_ONE;
            rot_zflag = 1'b0;
            rot_sin   = (y == '0) ? Q_ONE : y;
            held_w    = Q_ONE;
         end else begin
            rot_cos   = q_div(y, x);
            rot_sin   = y;
            rot_zflag = 1'b1;
            held_w    = q_div(q_mul(w, x), r.x_out);
         end
      end else begin
         r.x_out = q_add(rot_zflag ? x : '0, q_mul(q_mul(w, rot_sin), y));
         r.y_out = q_sub(rot_zflag ? y : '0, q_mul(rot_cos, x));
      end
      r.w_out = held_w;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic gr_word_type fx(real v);
      return gr_word_type'($rtoi(v * (2.0 ** FB)));
   endfunction

   function automatic gr_req_type make_req(logic kind, gr_word_type x, gr_word_type y,
                                           gr_word_type w);
      gr_req_type t;
      t.req_type = kind;
      t.x_in     = x;
      t.y_in     = y;
      t.w_in     = w;
      return t;
   endfunction

   // Operand mix: half moderate values up to 4.0 in magnitude, plus zeros, landmarks,
   // tiny values and the full 32-bit range so every bit toggles.
   function automatic gr_word_type rand_word();
      gr_word_type v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: begin
            case ($urandom_range(0, 5))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = Q_ONE;
               3: v = -Q_ONE;
               4: v = Q_ULP;
               default: v = -Q_ULP;
            endcase
         end
         2, 3: v = $urandom;
         4: v = gr_word_type'($urandom_range(0, 255));
         default: v = gr_word_type'($urandom_range(0, 32'h0400_0000));
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // Present one transaction, wait for the handshake and log its outputs.
   // Called right after the clock rises; requests come in bursts of random length,
   // separated by random gaps (possibly none) with req_valid low.
   task automatic drive_transaction(gr_req_type item);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 19))
            0, 1, 2:             gap = $urandom_range(1, 250);
            3, 4, 5, 6, 7, 8, 9: gap = $urandom_range(1, 8);
            default:             gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cell_outputs_due.insert(cell_outputs_due.size(), givens_step(item));
      burst_left--;
   endtask

   // Drop valid and hold until every logged output has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (cell_outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, gr_word_type got, gr_word_type want);
      $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall on a pattern of its own, check each transaction
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      cycle_count++;
      // switch stall intensity periodically, including none
      if (cycle_count % 300 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 5;
            2: stall_pct = 30;
            default: stall_pct = 70;
         endcase
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cell_outputs_due.size() == 0) begin
            report_mismatch("transaction with nothing due, x_out", rsp_data.x_out, '0);
         end else begin
            oldest_due = cell_outputs_due.pop_front();
            if (rsp_data.x_out !== oldest_due.x_out)
               report_mismatch("x_out", rsp_data.x_out, oldest_due.x_out);
            if (rsp_data.y_out !== oldest_due.y_out)
               report_mismatch("y_out", rsp_data.y_out, oldest_due.y_out);
            if (rsp_data.w_out !== oldest_due.w_out)
               report_mismatch("w_out", rsp_data.w_out, oldest_due.w_out);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Apply with the reset terms: c = s = z = 0 and weight 0.
   task automatic test_apply_before_generate();
      drive_transaction(make_req(REQ_APPLY, Q_MAX, Q_MIN, Q_ONE));
      drive_transaction(make_req(REQ_APPLY, Q_MIN, Q_MAX, Q_MIN));
   endtask

   // Zero x takes the special path; check both y zero and y nonzero, and
   // the apply that follows with z cleared.
   task automatic test_zero_x_generate();
      drive_transaction(make_req(REQ_GENERATE, '0, '0, fx(3.0)));
      drive_transaction(make_req(REQ_APPLY, Q_ONE, -Q_ONE, fx(2.0)));
      drive_transaction(make_req(REQ_GENERATE, '0, fx(-1.5), Q_MIN));
      drive_transaction(make_req(REQ_APPLY, Q_MAX, Q_MIN, Q_ONE));
   endtask

   // Ordinary rotation and applies; pause the sender mid-row until drained.
   task automatic test_rotation_row();
      drive_transaction(make_req(REQ_GENERATE, fx(2.0), fx(1.0), fx(0.5)));
      drive_transaction(make_req(REQ_APPLY, fx(1.5), fx(-0.75), fx(0.25)));
      drive_transaction(make_req(REQ_APPLY, fx(-3.0), fx(2.0), fx(1.0)));
      hold_until_drained();
      drive_transaction(make_req(REQ_APPLY, '0, '0, '0));
      drive_transaction(make_req(REQ_GENERATE, fx(-1.25), fx(3.5), fx(-0.5)));
      drive_transaction(make_req(REQ_APPLY, fx(0.5), fx(-2.0), fx(1.5)));
   endtask

   // Field extremes: overflow in add and multiply, one-ulp operands.
   task automatic test_field_extremes();
      drive_transaction(make_req(REQ_GENERATE, Q_MAX, Q_MAX, Q_MAX));
      drive_transaction(make_req(REQ_APPLY, Q_MAX, Q_MAX, Q_MAX));
      drive_transaction(make_req(REQ_GENERATE, Q_MIN, Q_MIN, Q_MIN));
      drive_transaction(make_req(REQ_APPLY, Q_MIN, Q_MIN, Q_MIN));
      drive_transaction(make_req(REQ_GENERATE, Q_ULP, -Q_ULP, Q_MAX));
      drive_transaction(make_req(REQ_APPLY, -Q_ULP, Q_ULP, -Q_ULP));
   endtask

   // x_out becoming zero with x nonzero: negative dividend saturates to the
   // most negative value, a dividend that rounds to zero gives zero.
   task automatic test_divide_by_zero();
      drive_transaction(make_req(REQ_GENERATE, -Q_ONE, Q_ONE, Q_ONE));
      drive_transaction(make_req(REQ_APPLY, Q_ONE, Q_ONE, Q_ONE));
      drive_transaction(make_req(REQ_GENERATE, -Q_ULP, Q_ONE, Q_ULP));
      drive_transaction(make_req(REQ_APPLY, Q_MIN, Q_MIN, Q_MAX));
   endtask

   // Mostly well-formed rows (one generate, then applies), some noise of
   // random kinds, and an occasional full drain.
   task automatic test_random_rows();
      int sent;
      int row_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            row_len = $urandom_range(1, 8);
            drive_transaction(make_req(REQ_GENERATE, rand_word(), rand_word(), rand_word()));
            repeat (row_len)
               drive_transaction(make_req(REQ_APPLY, rand_word(), rand_word(), rand_word()));
            sent += row_len + 1;
         end else begin
            row_len = $urandom_range(1, 4);
            repeat (row_len)
               drive_transaction(make_req($urandom_range(0, 1) ? REQ_GENERATE : REQ_APPLY,
                                          rand_word(), rand_word(), rand_word()));
            sent += row_len;
         end
         if ($urandom_range(0, 99) == 0) hold_until_drained();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      rot_cos   = '0;
      rot_sin   = '0;
      rot_zflag = 1'b0;
      held_w    = '0;

      test_apply_before_generate();
      test_zero_x_generate();
      test_rotation_row();
      test_field_extremes();
      test_divide_by_zero();
      test_random_rows();

      // release the request side, then let the last results drain
      req_valid <= 1'b0;
      while (cell_outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
src/gr_cell_pkg.sv
src/gr_cell_arith.sv
src/givens_rotation_internal_cell_core.sv
tb/givens_rotation_internal_cell_core_tb.sv
